### hw/rtl/ip_id_lsb_bit_embedder_top_defines.svh
// ----------------------------------------------------------------------------
// IP ID LSB embedder assertion macros
// Shared property wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef IP_ID_LSB_BIT_EMBEDDER_TOP_DEFINES_SVH
`define IP_ID_LSB_BIT_EMBEDDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IPEMB_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define IPEMB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ipemb_pkg.sv
// ----------------------------------------------------------------------------
// IP ID LSB embedder package
// Word types, mode codes and sizing constants shared by the embedder files.
// ----------------------------------------------------------------------------
`default_nettype none

package ipemb_pkg;

  // Message store depth in bytes (1 .. 256)
  localparam int MSG_BYTES = 256;
  localparam int MSG_AW    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

  // Protocol numbers that carry a bit
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Header checks
  localparam logic [3:0] IP_V4       = 4'd4;
  localparam logic [3:0] IHL_MIN     = 4'd5;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_PACKET = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  msg_index;
    logic [7:0]  msg_byte;
    logic [8:0]  msg_length;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic        more_fragments;
    logic [12:0] fragment_offset;
    logic [7:0]  protocol;
    logic        transport_present;
    logic [15:0] ident;
    logic [15:0] checksum;
  } req_t;

  typedef struct packed {
    logic        embedded;
    logic [15:0] out_id;
    logic [15:0] out_checksum;
    logic        tx_active;
    logic [11:0] bit_position;
    logic [8:0]  message_length;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/ip_id_lsb_bit_embedder_top.sv
// ----------------------------------------------------------------------------
// IP ID LSB bit embedder
// Places one stored message bit per qualifying IPv4 TCP/UDP packet into the
// ID low bit and patches the header checksum incrementally.
//
//   channel | handshake            | payload | word
//   --------+----------------------+---------+----------------------------
//   req     | req_valid/req_ready  | req     | load byte, arm, or packet
//   rsp     | rsp_valid/rsp_ready  | rsp     | one result per req word
//
// One word accepted per cycle while rsp is not stalled; its result passes stage 1 and the output register.
// Control state updates and the message RAM read issue at acceptance, so the
// single RAM read port sets the one-word-per-cycle rate.
// A stalled rsp holds the whole two-stage pipe; req_ready drops only then.
// rst is synchronous; the message RAM has no reset and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_id_lsb_bit_embedder_top
  import ipemb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  // Control state
  logic [8:0]  length_bytes, length_bytes_next;
  logic [11:0] next_bit_index, next_bit_index_next;
  logic        armed, armed_next;

  // Stage 1 registers (RAM read in flight)
  logic        s1_valid;
  logic        s1_pkt;
  logic        s1_embed;
  logic [15:0] s1_ident;
  logic [15:0] s1_checksum;
  logic [2:0]  s1_bit_sel;
  logic        s1_tx_active;
  logic [11:0] s1_bit_position;
  logic [8:0]  s1_message_length;

  logic        advance;
  logic        accept;
  logic        qualifies;
  logic        bits_remain;
  logic        embed;
  logic        is_load;
  logic        is_arm;
  logic        is_pkt;
  logic        tx_active_next;
  logic [7:0]  ram_rdata;
  logic        msg_bit;
  logic [15:0] new_id;
  logic [17:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  rsp_t        rsp_next;

  // Whole pipe moves when the output register is free or being drained
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;
  assign accept    = req_valid && advance;

  assign is_load = (req.mode == MODE_LOAD);
  assign is_arm  = (req.mode == MODE_ARM);
  assign is_pkt  = (req.mode == MODE_PACKET);

  // Check the header summary
  assign qualifies = (req.ip_version == IP_V4) && (req.header_words >= IHL_MIN) &&
                     !req.more_fragments && (req.fragment_offset == 13'd0) &&
                     ((req.protocol == PROTO_TCP) || (req.protocol == PROTO_UDP)) &&
                     req.transport_present;

  assign bits_remain = armed && (next_bit_index < {length_bytes, 3'b000});
  assign embed       = is_pkt && qualifies && bits_remain;

  // Next control state
  always_comb begin
    length_bytes_next   = length_bytes;
    next_bit_index_next = next_bit_index;
    armed_next          = armed;
    if (is_arm && ({4'b0, req.msg_length} <= 13'(MSG_BYTES))) begin
      length_bytes_next   = req.msg_length;
      next_bit_index_next = 12'd0;
      armed_next          = (req.msg_length != 9'd0);
    end else if (embed) begin
      next_bit_index_next = next_bit_index + 12'd1;
      if (next_bit_index_next >= {length_bytes, 3'b000}) begin
        armed_next = 1'b0;
      end
    end
  end

  assign tx_active_next = armed_next && (next_bit_index_next < {length_bytes_next, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      length_bytes   <= 9'd0;
      next_bit_index <= 12'd0;
      armed          <= 1'b0;
    end else if (accept) begin
      length_bytes   <= length_bytes_next;
      next_bit_index <= next_bit_index_next;
      armed          <= armed_next;
    end
  end

  // Message store: write on load, read the current byte on every accept
  ipemb_ram #(
    .WIDTH (8),
    .DEPTH (MSG_BYTES)
  ) u_msg_ram (
    .clk     (clk),
    .wr_en   (accept && is_load && ({4'b0, req.msg_index} < 12'(MSG_BYTES))),
    .wr_addr (MSG_AW'(req.msg_index)),
    .wr_data (req.msg_byte),
    .rd_en   (accept),
    .rd_addr (MSG_AW'(next_bit_index[11:3])),
    .rd_data (ram_rdata)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req_valid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pkt            <= is_pkt;
      s1_embed          <= embed;
      s1_ident          <= req.ident;
      s1_checksum       <= req.checksum;
      s1_bit_sel        <= next_bit_index[2:0];
      s1_tx_active      <= tx_active_next;
      s1_bit_position   <= next_bit_index_next;
      s1_message_length <= length_bytes_next;
    end
  end

  // Pick the message bit, MSB first, and patch the checksum
  assign msg_bit = ram_rdata[~s1_bit_sel];
  assign new_id  = {s1_ident[15:1], msg_bit};
  assign sum     = {2'b00, ~s1_checksum} + {2'b00, ~s1_ident} + {2'b00, new_id};
  assign fold1   = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
  assign fold2   = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    rsp_next.embedded       = s1_embed;
    rsp_next.out_id         = 16'd0;
    rsp_next.out_checksum   = 16'd0;
    rsp_next.tx_active      = s1_tx_active;
    rsp_next.bit_position   = s1_bit_position;
    rsp_next.message_length = s1_message_length;
    if (s1_embed) begin
      rsp_next.out_id       = new_id;
      rsp_next.out_checksum = ~fold2;
    end else if (s1_pkt) begin
      rsp_next.out_id       = s1_ident;
      rsp_next.out_checksum = s1_checksum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipemb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipemb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipemb_checker.sv
// ----------------------------------------------------------------------------
// IP ID LSB embedder port checker
// Watches the top-level ports for handshake and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_id_lsb_bit_embedder_top_defines.svh"

module ipemb_checker
  import ipemb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  logic       req_seen;
  logic [1:0] req_mode;

  // Track last accepted mode for the packet-field check
  assign req_seen = req_valid && req_ready;
  assign req_mode = req.mode;

  // Hold a stalled result
  `IPEMB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp word changed while stalled")

  // Drop ready only while a result waits
  `IPEMB_ASSERT_IMPL(a_ready_free, clk, rst, !rsp_valid, req_ready, "req_ready low with empty output")

  // An embedded bit advances the position within the message
  `IPEMB_ASSERT_IMPL(a_embed_pos, clk, rst, rsp_valid && rsp.embedded, (rsp.bit_position != 12'd0) && (rsp.bit_position <= {rsp.message_length, 3'b000}), "embedded bit outside message")

  // Active sending leaves bits ahead of the position
  `IPEMB_ASSERT_IMPL(a_active_pos, clk, rst, rsp_valid && rsp.tx_active, rsp.bit_position < {rsp.message_length, 3'b000}, "tx_active with no bits left")

  // Non-packet words produce a result with no embedding and zero packet fields
  `IPEMB_ASSERT_IMPL(a_nonpkt_clear, clk, rst, $past(req_seen && (req_mode != MODE_PACKET), 2) && $past(rsp_ready, 1) && rsp_valid && $past(!rsp_valid || rsp_ready, 2), !rsp.embedded && (rsp.out_id == 16'd0) && (rsp.out_checksum == 16'd0), "non-packet word shows packet fields")

endmodule

bind ip_id_lsb_bit_embedder_top ipemb_checker u_ipemb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
